FILE: rtl/core/rdc_pkg.sv
// Package for the radix digit converter.
// Holds the field widths, ASCII constants, state encoding and the divider status struct.
// Depends on nothing.
`default_nettype none

package rdc_pkg;

   localparam int VALUE_W = 31;
   localparam int BASE_W = 5;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W = 7;
   localparam int STACK_DEPTH_DEFAULT = 32;

   localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
   localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
   localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;
   localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_POP_READ,
      ST_POP_EMIT
   } state_type;

   typedef struct packed {
      logic done;
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   function automatic logic [BASE_W-1:0] saturate_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end else begin
         r = b;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DECIMAL_LIMIT) begin
         c = ASCII_ZERO + CHAR_W'(d);
      end else begin
         c = ASCII_UPPER_A + CHAR_W'(d - DECIMAL_LIMIT);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rdc_divider.sv
// Iterative restoring divider for the radix digit converter.
// Produces one quotient bit per cycle; depends on rdc_pkg.
`default_nettype none

module rdc_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rdc_pkg::VALUE_W-1:0]   dividend,
   input  wire logic [rdc_pkg::BASE_W-1:0]    divisor,
   output rdc_pkg::div_status_type            status
);
   import rdc_pkg::*;

   localparam int COUNT_W = $clog2(VALUE_W);
   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(VALUE_W - 1);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0]   quot_ff, quot_in;
   logic [BASE_W-1:0]    rem_ff, rem_in;
   logic [BASE_W-1:0]    divisor_ff, divisor_in;
   logic [BASE_W:0]      trial;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, quot_ff[VALUE_W-1]};
      fits = trial >= {1'b0, divisor_ff};
      active_in = active_ff;
      done_in = 1'b0;
      count_in = count_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         active_in = 1'b1;
         count_in = '0;
         quot_in = dividend;
         rem_in = '0;
         divisor_in = divisor;
      end else if (active_ff) begin
         quot_in = {quot_ff[VALUE_W-2:0], fits};
         rem_in = fits ? BASE_W'(trial - {1'b0, divisor_ff}) : trial[BASE_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_COUNT) begin
            active_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         active_ff <= active_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.done = done_ff;
   assign status.quotient = quot_ff;
   assign status.remainder = rem_ff[DIGIT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/radix_digit_converter.sv
// Top level of the radix digit converter: sequencer, digit stack and base register.
// Depends on rdc_pkg and rdc_divider.
`default_nettype none

// Converts a non-negative value into ASCII digits in the configured base, most significant
// first, with rsp_last_digit on the final digit. Each digit takes one pass of the shared
// bit-serial divider, started from ST_DIV_START, and later a read of the digit stack in
// ST_POP_READ and the transfer in ST_POP_EMIT; busy stays high until the last digit has
// been presented, and a value has at most 31 digits, in base 2.
// Results come one per strobe and cannot be held off; the receiver must take every transfer.

module radix_digit_converter #(
   parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rdc_pkg::VALUE_W-1:0]   req_value,
   output logic                               rsp_valid,
   output logic [rdc_pkg::CHAR_W-1:0]         rsp_digit_char,
   output logic                               rsp_last_digit,
   input  wire logic                          csr_write_enable,
   input  wire logic [rdc_pkg::BASE_W-1:0]    csr_write_data
);
   import rdc_pkg::*;

   localparam int PTR_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam logic [PTR_W-1:0] DEPTH_LIMIT = PTR_W'(STACK_DEPTH);

   state_type             state_ff, state_in;
   logic [BASE_W-1:0]     base_ff;
   logic [BASE_W-1:0]     eff_base_ff, eff_base_in;
   logic [VALUE_W-1:0]    quotient_ff, quotient_in;
   logic [PTR_W-1:0]      sp_ff, sp_in;
   logic [DIGIT_W-1:0]    stack_mem [STACK_DEPTH];
   logic [DIGIT_W-1:0]    rd_data_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [PTR_W-1:0]      sp_dec;
   logic                  div_start;
   div_status_type        div_status;

   rdc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (quotient_ff),
      .divisor  (eff_base_ff),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   assign sp_dec = sp_ff - 1'b1;
   assign wr_addr = sp_ff[ADDR_W-1:0];
   assign rd_addr = sp_dec[ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      eff_base_in = eff_base_ff;
      quotient_in = quotient_ff;
      sp_in = sp_ff;
      wr_en = 1'b0;
      div_start = 1'b0;
      rsp_valid = 1'b0;
      rsp_last_digit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               quotient_in = req_value;
               eff_base_in = saturate_base(base_ff);
               sp_in = '0;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               quotient_in = div_status.quotient;
               if (sp_ff < DEPTH_LIMIT) begin
                  wr_en = 1'b1;
                  sp_in = sp_ff + 1'b1;
               end
               state_in = (div_status.quotient == '0) ? ST_POP_READ : ST_DIV_START;
            end
         end
         ST_POP_READ: begin
            sp_in = sp_dec;
            state_in = ST_POP_EMIT;
         end
         ST_POP_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last_digit = (sp_ff == '0);
            state_in = (sp_ff == '0) ? ST_IDLE : ST_POP_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_digit_char = digit_to_ascii(rd_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff <= '0;
         quotient_ff <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
         quotient_ff <= quotient_in;
      end
      eff_base_ff <= eff_base_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= div_status.remainder;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_digit) |=> !busy)
      else $error("block still busy after the last digit");

   a_busy_falls_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> ($past(reset) || $past(rsp_valid && rsp_last_digit)))
      else $error("run ended without a last digit");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= ASCII_ZERO && rsp_digit_char <= 7'd57) ||
                     (rsp_digit_char >= ASCII_UPPER_A && rsp_digit_char <= 7'd70)))
      else $error("digit character out of range");

endmodule

`default_nettype wire
